>>> hdl/tfr_pkg.sv
// shared types, constants and font table for the text frame buffer renderer
package tfr_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int PAGE_COUNT    = SCREEN_HEIGHT / 8;
    localparam int STORE_SIZE    = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W        = $clog2(STORE_SIZE);
    localparam int CHAR_ADVANCE  = 6;
    localparam int GLYPH_COLS    = 5;
    localparam int GLYPH_COUNT   = 40;

    // glyph table slots
    localparam logic [5:0] GLYPH_DIGIT0 = 6'd0;
    localparam logic [5:0] GLYPH_ALPHA0 = 6'd10;
    localparam logic [5:0] GLYPH_COLON  = 6'd36;
    localparam logic [5:0] GLYPH_DOT    = 6'd37;
    localparam logic [5:0] GLYPH_DASH   = 6'd38;
    localparam logic [5:0] GLYPH_BLANK  = 6'd39;

    // rows touched by one merge
    localparam logic [6:0] PIXEL_ROW_MASK = 7'h01;
    localparam logic [6:0] GLYPH_ROW_MASK = 7'h7F;

    typedef enum logic [2:0] {
        OP_PIXEL  = 3'd0,
        OP_CURSOR = 3'd1,
        OP_CHAR   = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] x_pos;
        logic [7:0] y_pos;
        logic       pixel_on;
        logic [7:0] char_code;
        logic [6:0] read_column;
        logic [2:0] read_page;
    } tfr_in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       char_dropped;
    } tfr_out_t;

    // one read-modify-write request to the merge unit
    typedef struct packed {
        logic [6:0] line;
        logic [6:0] row_mask;
        logic [2:0] row_offset;
        logic       lower_page;
        logic [7:0] old_byte;
    } merge_req_t;

    // columns 0..4 from left, bit r is glyph row r
    localparam logic [39:0] FONT_ROM [GLYPH_COUNT] = '{
        40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46,
        40'h21_41_45_4B_31, 40'h18_14_12_7F_10, 40'h27_45_45_45_39,
        40'h3C_4A_49_49_30, 40'h01_71_09_05_03, 40'h36_49_49_49_36,
        40'h06_49_49_29_1E,
        40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
        40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_09_01,
        40'h3E_41_49_49_7A, 40'h7F_08_08_08_7F, 40'h00_41_7F_41_00,
        40'h20_40_41_3F_01, 40'h7F_08_14_22_41, 40'h7F_40_40_40_40,
        40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
        40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46,
        40'h46_49_49_49_31, 40'h01_01_7F_01_01, 40'h3F_40_40_40_3F,
        40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F, 40'h63_14_08_14_63,
        40'h07_08_70_08_07, 40'h61_51_49_45_43,
        40'h00_36_36_00_00, 40'h00_40_60_00_00, 40'h08_08_08_08_08,
        40'h00_00_00_00_00
    };

    // character code to glyph slot, lowercase folds to uppercase
    function automatic logic [5:0] glyph_index(input logic [7:0] code);
        logic [7:0] c;
        logic [5:0] idx;
        begin
            c = code;
            if (c >= 8'h61 && c <= 8'h7A)
                c = c - 8'h20;
            if (c >= 8'h30 && c <= 8'h39)
                idx = GLYPH_DIGIT0 + 6'(c - 8'h30);
            else if (c >= 8'h41 && c <= 8'h5A)
                idx = GLYPH_ALPHA0 + 6'(c - 8'h41);
            else if (c == 8'h3A)
                idx = GLYPH_COLON;
            else if (c == 8'h2E)
                idx = GLYPH_DOT;
            else if (c == 8'h2D)
                idx = GLYPH_DASH;
            else
                idx = GLYPH_BLANK;
            return idx;
        end
    endfunction

    // one glyph column, spacer column and beyond are blank
    function automatic logic [6:0] glyph_column(input logic [5:0] idx,
                                                input logic [2:0] col);
        logic [39:0] g;
        logic [6:0]  line;
        begin
            g = FONT_ROM[idx];
            unique case (col)
                3'd0:    line = g[38:32];
                3'd1:    line = g[30:24];
                3'd2:    line = g[22:16];
                3'd3:    line = g[14:8];
                3'd4:    line = g[6:0];
                default: line = 7'h00;
            endcase
            return line;
        end
    endfunction

endpackage

>>> hdl/tfr_store.sv
// frame store memory, one port, registered read
module tfr_store (
    input  logic                      clk,
    input  logic                      we,
    input  logic                      re,
    input  logic [tfr_pkg::ADDR_W-1:0] addr,
    input  logic [7:0]                wdata,
    output logic [7:0]                rdata
);

    logic [7:0] mem [tfr_pkg::STORE_SIZE];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/tfr_merge_unit.sv
// shared shift and merge unit: places glyph or pixel rows into a page byte
module tfr_merge_unit (
    input  tfr_pkg::merge_req_t req,
    output logic [7:0]          new_byte
);

    logic [6:0]  line_rev;
    logic [6:0]  mask_rev;
    logic [15:0] pat_win;
    logic [15:0] mask_win;
    logic [7:0]  pat_sel;
    logic [7:0]  mask_sel;

    // row r goes to window position offset+r, counted from the msb
    always_comb
    begin
        for (int i = 0; i < 7; i++)
        begin
            line_rev[i] = req.line[6 - i];
            mask_rev[i] = req.row_mask[6 - i];
        end
    end

    assign pat_win  = {line_rev, 9'b0} >> req.row_offset;
    assign mask_win = {mask_rev, 9'b0} >> req.row_offset;
    assign pat_sel  = req.lower_page ? pat_win[7:0]  : pat_win[15:8];
    assign mask_sel = req.lower_page ? mask_win[7:0] : mask_win[15:8];
    assign new_byte = (req.old_byte & ~mask_sel) | (pat_sel & mask_sel);

endmodule

>>> hdl/text_frame_buffer_renderer.sv
// top level of the page-organized text frame buffer renderer
//
//  channel   ports                     handshake
//  -------   -----------------------   ------------------------------------------
//  command   start, busy, command      item taken on clk edge with start & !busy
//  result    done, result              one item per command, valid one cycle
//
// a text char goes through six columns, each a read then a write on one or two page
// bytes through the single store port; clear writes one byte a cycle
// reset: busy stays high through a zeroing sweep of the whole store that gives no result
// the receiver cannot stall: done is a one-cycle strobe, and busy drops in the
// same cycle so the next item can be taken while the result is shown
module text_frame_buffer_renderer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tfr_pkg::tfr_in_t  command,
    output logic              done,
    output tfr_pkg::tfr_out_t result
);

    localparam int AW = tfr_pkg::ADDR_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_PIX_WR,
        ST_READ_WAIT,
        ST_CHAR_CHK,
        ST_CHAR_RD,
        ST_CHAR_WR,
        ST_CLEAR
    } state_t;

    state_t            state_reg;
    tfr_pkg::tfr_in_t  cmd_reg;
    tfr_pkg::tfr_out_t result_reg;
    logic              done_reg;
    logic [7:0]        cursor_col_reg;
    logic [7:0]        cursor_row_reg;
    logic [5:0]        glyph_reg;
    logic [2:0]        col_idx_reg;
    logic              half_reg;
    logic              two_pages_reg;
    logic              clear_op_reg;
    logic [AW-1:0]     base_reg;
    logic [AW-1:0]     addr_reg;
    logic [AW-1:0]     clr_addr_reg;

    // store port
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_addr;
    logic [7:0]        mem_wdata;
    logic [7:0]        mem_rdata;

    // shared merge unit
    tfr_pkg::merge_req_t merge_req;
    logic [7:0]          merge_byte;

    // decoded addresses and checks
    logic              pix_on_screen;
    logic [AW-1:0]     pix_addr;
    logic              read_in_range;
    logic [AW-1:0]     read_addr;
    logic [AW-1:0]     char_addr;
    logic              col_wraps;
    logic              row_below;
    logic              last_half;

    // pixel: page counts from the bottom, bit 7 is the top row of a page
    assign pix_on_screen = (int'(cmd_reg.x_pos) < tfr_pkg::SCREEN_WIDTH)
                        && (int'(cmd_reg.y_pos) < tfr_pkg::SCREEN_HEIGHT)
                        && (int'(cmd_reg.y_pos[7:3]) < tfr_pkg::PAGE_COUNT);
    assign pix_addr = AW'(int'(cmd_reg.x_pos) * tfr_pkg::PAGE_COUNT
                        + tfr_pkg::PAGE_COUNT - 1 - int'(cmd_reg.y_pos[7:3]));

    assign read_in_range = (int'(cmd_reg.read_column) < tfr_pkg::SCREEN_WIDTH)
                        && (int'(cmd_reg.read_page) < tfr_pkg::PAGE_COUNT);
    assign read_addr = AW'(int'(cmd_reg.read_column) * tfr_pkg::PAGE_COUNT
                         + int'(cmd_reg.read_page));

    // text: wrap past the right edge, drop below the last line
    assign col_wraps = int'(cursor_col_reg) > (tfr_pkg::SCREEN_WIDTH - tfr_pkg::CHAR_ADVANCE);
    assign row_below = int'(cursor_row_reg) > (tfr_pkg::SCREEN_HEIGHT - 8);
    // lower half is the page below, one address down
    assign char_addr = half_reg ? (base_reg - AW'(1)) : base_reg;
    assign last_half = half_reg || !two_pages_reg;

    // merge request comes from pixel or text state
    always_comb
    begin
        merge_req.old_byte = mem_rdata;
        if (state_reg == ST_CHAR_WR)
        begin
            merge_req.line       = tfr_pkg::glyph_column(glyph_reg, col_idx_reg);
            merge_req.row_mask   = tfr_pkg::GLYPH_ROW_MASK;
            merge_req.row_offset = cursor_row_reg[2:0];
            merge_req.lower_page = half_reg;
        end
        else
        begin
            merge_req.line       = {6'b0, cmd_reg.pixel_on};
            merge_req.row_mask   = tfr_pkg::PIXEL_ROW_MASK;
            merge_req.row_offset = cmd_reg.y_pos[2:0];
            merge_req.lower_page = 1'b0;
        end
    end

    tfr_merge_unit u_merge (
        .req      (merge_req),
        .new_byte (merge_byte)
    );

    // store port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = addr_reg;
        mem_wdata = merge_byte;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_addr_reg;
                mem_wdata = 8'h00;
            end
            ST_DISPATCH:
            begin
                mem_re   = 1'b1;
                mem_addr = (cmd_reg.op == tfr_pkg::OP_READ) ? read_addr : pix_addr;
            end
            ST_CHAR_RD:
            begin
                mem_re   = 1'b1;
                mem_addr = char_addr;
            end
            ST_PIX_WR, ST_CHAR_WR:
            begin
                mem_we = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    tfr_store u_store (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            done_reg       <= 1'b0;
            result_reg     <= '0;
            cursor_col_reg <= 8'd0;
            cursor_row_reg <= 8'd0;
            col_idx_reg    <= 3'd0;
            half_reg       <= 1'b0;
            two_pages_reg  <= 1'b0;
            clear_op_reg   <= 1'b0;
            clr_addr_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg   <= command;
                        state_reg <= ST_DISPATCH;
                    end
                end

                ST_DISPATCH:
                begin
                    unique case (cmd_reg.op)
                        tfr_pkg::OP_PIXEL:
                        begin
                            addr_reg <= pix_addr;
                            if (pix_on_screen)
                            begin
                                state_reg <= ST_PIX_WR;
                            end
                            else
                            begin
                                result_reg <= '0;
                                done_reg   <= 1'b1;
                                state_reg  <= ST_IDLE;
                            end
                        end
                        tfr_pkg::OP_CURSOR:
                        begin
                            cursor_col_reg <= cmd_reg.x_pos;
                            cursor_row_reg <= cmd_reg.y_pos;
                            result_reg     <= '0;
                            done_reg       <= 1'b1;
                            state_reg      <= ST_IDLE;
                        end
                        tfr_pkg::OP_CHAR:
                        begin
                            // wrap sticks even if the char is dropped
                            if (col_wraps)
                            begin
                                cursor_col_reg <= 8'd0;
                                cursor_row_reg <= cursor_row_reg + 8'd8;
                            end
                            glyph_reg <= tfr_pkg::glyph_index(cmd_reg.char_code);
                            state_reg <= ST_CHAR_CHK;
                        end
                        tfr_pkg::OP_CLEAR:
                        begin
                            clr_addr_reg <= '0;
                            clear_op_reg <= 1'b1;
                            state_reg    <= ST_CLEAR;
                        end
                        tfr_pkg::OP_READ:
                        begin
                            if (read_in_range)
                            begin
                                state_reg <= ST_READ_WAIT;
                            end
                            else
                            begin
                                result_reg <= '0;
                                done_reg   <= 1'b1;
                                state_reg  <= ST_IDLE;
                            end
                        end
                        default:
                        begin
                            result_reg <= '0;
                            done_reg   <= 1'b1;
                            state_reg  <= ST_IDLE;
                        end
                    endcase
                end

                ST_READ_WAIT:
                begin
                    result_reg.read_data    <= mem_rdata;
                    result_reg.char_dropped <= 1'b0;
                    done_reg                <= 1'b1;
                    state_reg               <= ST_IDLE;
                end

                ST_PIX_WR:
                begin
                    result_reg <= '0;
                    done_reg   <= 1'b1;
                    state_reg  <= ST_IDLE;
                end

                ST_CHAR_CHK:
                begin
                    if (row_below)
                    begin
                        result_reg.read_data    <= 8'h00;
                        result_reg.char_dropped <= 1'b1;
                        done_reg                <= 1'b1;
                        state_reg               <= ST_IDLE;
                    end
                    else
                    begin
                        base_reg <= AW'(int'(cursor_col_reg) * tfr_pkg::PAGE_COUNT
                                        + tfr_pkg::PAGE_COUNT - 1
                                        - int'(cursor_row_reg[7:3]));
                        // rows spill into the page below when it exists
                        two_pages_reg <= (cursor_row_reg[2:0] >= 3'd2)
                                      && (int'(cursor_row_reg[7:3]) < tfr_pkg::PAGE_COUNT - 1);
                        col_idx_reg <= 3'd0;
                        half_reg    <= 1'b0;
                        state_reg   <= ST_CHAR_RD;
                    end
                end

                ST_CHAR_RD:
                begin
                    addr_reg  <= char_addr;
                    state_reg <= ST_CHAR_WR;
                end

                ST_CHAR_WR:
                begin
                    if (!last_half)
                    begin
                        half_reg  <= 1'b1;
                        state_reg <= ST_CHAR_RD;
                    end
                    else if (int'(col_idx_reg) == tfr_pkg::CHAR_ADVANCE - 1)
                    begin
                        cursor_col_reg <= cursor_col_reg + 8'(tfr_pkg::CHAR_ADVANCE);
                        result_reg     <= '0;
                        done_reg       <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                    else
                    begin
                        col_idx_reg <= col_idx_reg + 3'd1;
                        half_reg    <= 1'b0;
                        base_reg    <= AW'(int'(base_reg) + tfr_pkg::PAGE_COUNT);
                        state_reg   <= ST_CHAR_RD;
                    end
                end

                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == AW'(tfr_pkg::STORE_SIZE - 1))
                    begin
                        // the sweep after reset gives no result
                        if (clear_op_reg)
                        begin
                            result_reg <= '0;
                            done_reg   <= 1'b1;
                        end
                        clear_op_reg <= 1'b0;
                        state_reg    <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> bench/text_frame_checker.sv
`timescale 1ns / 100ps
// checker that predicts and compares every result of the text frame buffer renderer
module text_frame_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  tfr_pkg::tfr_in_t  command,
    input  logic              done,
    input  tfr_pkg::tfr_out_t result,
    output int                mismatches,
    output int                pending,
    output int                checked,
    output int                dropped,
    output int                lit_reads
);

    // glyph columns left to right, one byte each, bit r is glyph row r
    localparam logic [39:0] DIGIT_GLYPHS [10] = '{
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E
    };
    localparam logic [39:0] LETTER_GLYPHS [26] = '{
        40'h7E1111117E, 40'h7F49494936, 40'h3E41414122, 40'h7F4141221C,
        40'h7F49494941, 40'h7F09090901, 40'h3E4149497A, 40'h7F0808087F,
        40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906,
        40'h3E4151215E, 40'h7F09192946, 40'h4649494931, 40'h01017F0101,
        40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
        40'h0708700807, 40'h6151494543
    };
    localparam logic [39:0] COLON_GLYPH = 40'h0036360000;
    localparam logic [39:0] DOT_GLYPH   = 40'h0040600000;
    localparam logic [39:0] DASH_GLYPH  = 40'h0808080808;
    localparam logic [7:0]  LINE_ROWS   = 8'd8;

    logic [7:0]        frame [tfr_pkg::STORE_SIZE];
    logic [7:0]        cur_col;
    logic [7:0]        cur_row;
    tfr_pkg::tfr_out_t owed_results [$];
    tfr_pkg::tfr_out_t want;
    tfr_pkg::tfr_out_t fresh;
    int                bad_count;
    int                seen_count;
    int                drop_count;
    int                lit_count;

    function automatic logic [39:0] glyph_of(input logic [7:0] code);
        logic [7:0] folded;
        folded = (code >= "a" && code <= "z") ? code - ("a" - "A") : code;
        if (folded >= "0" && folded <= "9")
            return DIGIT_GLYPHS[folded - "0"];
        if (folded >= "A" && folded <= "Z")
            return LETTER_GLYPHS[folded - "A"];
        if (folded == ":")
            return COLON_GLYPH;
        if (folded == ".")
            return DOT_GLYPH;
        if (folded == "-")
            return DASH_GLYPH;
        return '0;
    endfunction

    // pages and bits are flipped, off-screen pixels are dropped
    task automatic plot(input logic [7:0] x, input logic [7:0] y, input logic on);
        int         idx;
        logic [7:0] mask;
        if (x >= tfr_pkg::SCREEN_WIDTH || y >= tfr_pkg::SCREEN_HEIGHT)
            return;
        idx  = int'(x) * tfr_pkg::PAGE_COUNT + (tfr_pkg::PAGE_COUNT - 1 - int'(y) / 8);
        mask = 8'h80 >> (y % 8);
        if (on)
            frame[idx] = frame[idx] | mask;
        else
            frame[idx] = frame[idx] & ~mask;
    endtask

    task automatic render_command(input tfr_pkg::tfr_in_t c, output tfr_pkg::tfr_out_t r);
        logic [39:0] g;
        logic [7:0]  line;
        r = '0;
        unique case (c.op)
            tfr_pkg::OP_PIXEL:
                plot(c.x_pos, c.y_pos, c.pixel_on);
            tfr_pkg::OP_CURSOR:
            begin
                cur_col = c.x_pos;
                cur_row = c.y_pos;
            end
            tfr_pkg::OP_CHAR:
            begin
                // wrap to next text line, kept even if the char is then dropped
                if (cur_col > tfr_pkg::SCREEN_WIDTH - tfr_pkg::CHAR_ADVANCE)
                begin
                    cur_col = '0;
                    cur_row = cur_row + LINE_ROWS;
                end
                if (cur_row > tfr_pkg::SCREEN_HEIGHT - LINE_ROWS)
                    r.char_dropped = 1'b1;
                else
                begin
                    g = glyph_of(c.char_code);
                    for (int col = 0; col < tfr_pkg::CHAR_ADVANCE; col++)
                    begin
                        line = (col < tfr_pkg::GLYPH_COLS) ? g[39 - 8 * col -: 8] : 8'h00;
                        for (int row = 0; row < 7; row++)
                            plot(cur_col + 8'(col), cur_row + 8'(row), line[row]);
                    end
                    cur_col = cur_col + 8'(tfr_pkg::CHAR_ADVANCE);
                end
            end
            tfr_pkg::OP_CLEAR:
                foreach (frame[i])
                    frame[i] = '0;
            tfr_pkg::OP_READ:
                if (c.read_column < tfr_pkg::SCREEN_WIDTH && c.read_page < tfr_pkg::PAGE_COUNT)
                    r.read_data = frame[int'(c.read_column) * tfr_pkg::PAGE_COUNT
                                        + int'(c.read_page)];
            default:
                ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (frame[i])
                frame[i] = '0;
            cur_col = '0;
            cur_row = '0;
            owed_results.delete();
            bad_count  = 0;
            seen_count = 0;
            drop_count = 0;
            lit_count  = 0;
            mismatches <= 0;
            pending    <= 0;
            checked    <= 0;
            dropped    <= 0;
            lit_reads  <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                render_command(command, fresh);
                owed_results.push_back(fresh);
            end
            if (done)
            begin
                if (owed_results.size() == 0)
                begin
                    if (bad_count < 10)
                        $display("unexpected result: read_data %02h char_dropped %0d",
                                 result.read_data, result.char_dropped);
                    bad_count++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    seen_count++;
                    if (result.read_data !== want.read_data ||
                        result.char_dropped !== want.char_dropped)
                    begin
                        if (bad_count < 10)
                        begin
                            $display("mismatch on result %0d (expected/got)", seen_count);
                            $display("  read_data %02h/%02h, char_dropped %0d/%0d",
                                     want.read_data, result.read_data,
                                     want.char_dropped, result.char_dropped);
                        end
                        bad_count++;
                    end
                    if (want.char_dropped)
                        drop_count++;
                    if (want.read_data != 0)
                        lit_count++;
                end
            end
            mismatches <= bad_count;
            pending    <= owed_results.size();
            checked    <= seen_count;
            dropped    <= drop_count;
            lit_reads  <= lit_count;
        end
    end

endmodule

>>> bench/text_frame_buffer_renderer_tb.sv
`timescale 1ns / 100ps
// top of the text frame buffer renderer bench: stimulus, idling and verdict
module text_frame_buffer_renderer_tb;

    // op codes the block does not define, they must answer zeros
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam int         ITEMS_PER_PHASE = 260;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    tfr_pkg::tfr_in_t  command;
    logic              done;
    tfr_pkg::tfr_out_t result;

    int mismatches;
    int pending;
    int checked;
    int dropped;
    int lit_reads;
    int idle_pct;
    int sent_items;

    text_frame_buffer_renderer u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .command (command),
        .done    (done),
        .result  (result)
    );

    // watches both channels, keeps its own frame store and compares results
    text_frame_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .done       (done),
        .result     (result),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked),
        .dropped    (dropped),
        .lit_reads  (lit_reads)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // generous limit on the whole run; a clear is the slowest item by far
    initial
    begin
        #1_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // one item with all unused fields random, so every bit sees both values;
    // a and b are x/y for pixel and cursor, code for a char, column/page for a read
    function automatic tfr_pkg::tfr_in_t make_item(input logic [2:0] op,
                                                   input logic [7:0] a,
                                                   input logic [7:0] b, input logic on);
        tfr_pkg::tfr_in_t it;
        it = tfr_pkg::tfr_in_t'({$urandom, $urandom});
        it.op = op;
        case (op)
            tfr_pkg::OP_PIXEL:
            begin
                it.x_pos    = a;
                it.y_pos    = b;
                it.pixel_on = on;
            end
            tfr_pkg::OP_CURSOR:
            begin
                it.x_pos = a;
                it.y_pos = b;
            end
            tfr_pkg::OP_CHAR:
                it.char_code = a;
            tfr_pkg::OP_READ:
            begin
                it.read_column = a[6:0];
                it.read_page   = b[2:0];
            end
            default:
                ;
        endcase
        return it;
    endfunction

    // mostly on-screen pixels, glyph characters and text-line cursor rows,
    // with some full-range values so the off-screen and blank cases stay busy
    function automatic tfr_pkg::tfr_in_t random_item();
        int         pick;
        int         k;
        logic [7:0] a;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 22)
        begin
            a = ($urandom_range(99) < 85) ? 8'($urandom_range(tfr_pkg::SCREEN_WIDTH - 1))
                                         : 8'($urandom_range(255));
            b = ($urandom_range(99) < 85) ? 8'($urandom_range(tfr_pkg::SCREEN_HEIGHT - 1))
                                         : 8'($urandom_range(255));
            return make_item(tfr_pkg::OP_PIXEL, a, b, 1'($urandom_range(1)));
        end
        if (pick < 32)
        begin
            a = ($urandom_range(99) < 85) ? 8'($urandom_range(tfr_pkg::SCREEN_WIDTH - 1))
                                         : 8'($urandom_range(255));
            k = $urandom_range(99);
            if (k < 60)
                b = 8'(8 * $urandom_range(tfr_pkg::PAGE_COUNT - 1));
            else if (k < 85)
                b = 8'($urandom_range(tfr_pkg::SCREEN_HEIGHT - 1));
            else
                b = 8'($urandom_range(255));
            return make_item(tfr_pkg::OP_CURSOR, a, b, 1'b0);
        end
        if (pick < 67)
        begin
            k = $urandom_range(38);
            if ($urandom_range(99) < 20)
                a = 8'($urandom_range(255));
            else if (k < 10)
                a = "0" + 8'(k);
            else if (k < 36)
                a = (($urandom_range(1) == 1) ? "a" : "A") + 8'(k - 10);
            else if (k == 36)
                a = ":";
            else if (k == 37)
                a = ".";
            else
                a = "-";
            return make_item(tfr_pkg::OP_CHAR, a, 8'h00, 1'b0);
        end
        if (pick < 94)
            return make_item(tfr_pkg::OP_READ, 8'($urandom_range(127)),
                             8'($urandom_range(7)), 1'b0);
        if (pick < 96)
            return make_item(tfr_pkg::OP_CLEAR, 8'h00, 8'h00, 1'b0);
        return make_item(3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)), 8'h00, 8'h00, 1'b0);
    endfunction

    // offer one item, possibly after an idle gap; returns at the edge that took it
    task automatic issue(input tfr_pkg::tfr_in_t item);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        start   <= 1'b1;
        command <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent_items++;
    endtask

    // hold the sender off until every outstanding result has come back
    task automatic drain_results();
        int waited;
        waited = 0;
        start <= 1'b0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (pending != 0 && waited < 4000);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        command    = '0;
        idle_pct   = 0;
        sent_items = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, busy covers the zeroing sweep after reset
        issue(make_item(tfr_pkg::OP_PIXEL, 8'd0, 8'd0, 1'b1));
        issue(make_item(tfr_pkg::OP_PIXEL, 8'd127, 8'd63, 1'b1));
        issue(make_item(tfr_pkg::OP_READ, 8'd0, 8'd7, 1'b0));
        issue(make_item(tfr_pkg::OP_READ, 8'd127, 8'd0, 1'b0));
        issue(make_item(tfr_pkg::OP_PIXEL, 8'd0, 8'd0, 1'b0));
        // off-screen pixels right, bottom and at the far corner are ignored
        issue(make_item(tfr_pkg::OP_PIXEL, 8'd128, 8'd5, 1'b1));
        issue(make_item(tfr_pkg::OP_PIXEL, 8'd3, 8'd64, 1'b1));
        issue(make_item(tfr_pkg::OP_PIXEL, 8'd255, 8'd255, 1'b1));
        issue(make_item(tfr_pkg::OP_CURSOR, 8'd0, 8'd0, 1'b0));
        // letters, lowercase fold, digit, punctuation and blank codes
        issue(make_item(tfr_pkg::OP_CHAR, "A", 8'h00, 1'b0));
        issue(make_item(tfr_pkg::OP_CHAR, "z", 8'h00, 1'b0));
        issue(make_item(tfr_pkg::OP_CHAR, "0", 8'h00, 1'b0));
        issue(make_item(tfr_pkg::OP_CHAR, ":", 8'h00, 1'b0));
        issue(make_item(tfr_pkg::OP_CHAR, ".", 8'h00, 1'b0));
        issue(make_item(tfr_pkg::OP_CHAR, "-", 8'h00, 1'b0));
        issue(make_item(tfr_pkg::OP_CHAR, 8'hFF, 8'h00, 1'b0));
        issue(make_item(tfr_pkg::OP_READ, 8'd1, 8'd7, 1'b0));
        // last column that still fits on the bottom line, then the next char
        // wraps below the last line and is dropped, twice
        issue(make_item(tfr_pkg::OP_CURSOR, 8'd122, 8'd56, 1'b0));
        issue(make_item(tfr_pkg::OP_CHAR, "W", 8'h00, 1'b0));
        issue(make_item(tfr_pkg::OP_CHAR, "M", 8'h00, 1'b0));
        issue(make_item(tfr_pkg::OP_CHAR, "8", 8'h00, 1'b0));
        // row wraps modulo 256 from the far corner back onto the screen
        issue(make_item(tfr_pkg::OP_CURSOR, 8'd255, 8'd255, 1'b0));
        issue(make_item(tfr_pkg::OP_CHAR, "8", 8'h00, 1'b0));
        issue(make_item(tfr_pkg::OP_READ, 8'd1, 8'd7, 1'b0));
        issue(make_item(tfr_pkg::OP_CLEAR, 8'h00, 8'h00, 1'b0));
        issue(make_item(tfr_pkg::OP_READ, 8'd1, 8'd7, 1'b0));
        for (int s = OP_SPARE_LO; s <= OP_SPARE_HI; s++)
            issue(make_item(3'(s), 8'h00, 8'h00, 1'b0));
        drain_results();

        // random part: light sender idling, then heavy, then none
        idle_pct = 16;
        repeat (ITEMS_PER_PHASE) issue(random_item());
        drain_results();
        idle_pct = 47;
        repeat (ITEMS_PER_PHASE) issue(random_item());
        drain_results();
        idle_pct = 0;
        repeat (ITEMS_PER_PHASE) issue(random_item());
        drain_results();

        // let any stray result show up before the verdict
        repeat (40) @(posedge clk);

        $display("run covered %0d items, %0d results checked, %0d mismatches",
                 sent_items, checked, mismatches);
        $display("text chars dropped below the last line: %0d, nonzero byte reads: %0d",
                 dropped, lit_reads);
        if (mismatches == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
